/* design/lfid_pkg.sv */
// Package: types and codes shared by the lowest-free identifier allocator.
`default_nettype none
package lfid_pkg;

    typedef logic [1:0] t_kind;
    typedef logic [7:0] t_id;
    typedef logic [1:0] t_status;
    typedef logic [8:0] t_limit;
    typedef logic       t_cfg_idx;

    localparam t_kind KIND_ALLOC   = 2'd0;
    localparam t_kind KIND_RELEASE = 2'd1;
    localparam t_kind KIND_RESERVE = 2'd2;

    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_FULL       = 2'd1;
    localparam t_status ST_NOT_IN_USE = 2'd2;
    localparam t_status ST_IN_USE     = 2'd3;

    localparam t_cfg_idx CFG_FIRST_ID = 1'b0;
    localparam t_cfg_idx CFG_ID_LIMIT = 1'b1;

    localparam t_id    FIRST_ID_RESET = 8'd0;
    localparam t_limit ID_LIMIT_RESET = 9'd256;

    localparam int WORD_BITS = 32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } t_state;

    // result of one word scan
    typedef struct packed {
        logic found;
        t_id  index;
    } t_scan_res;

endpackage
`default_nettype wire

/* design/lfid_req_if.sv */
// Request channel: valid/ready handshake carrying kind and id.
`default_nettype none
interface lfid_req_if;
    import lfid_pkg::*;

    logic  valid;
    logic  ready;
    t_kind kind;
    t_id   id;

    modport source (output valid, output kind, output id, input ready);
    modport sink   (input valid, input kind, input id, output ready);
endinterface
`default_nettype wire

/* design/lfid_rsp_if.sv */
// Response channel: valid/ready handshake carrying granted_id and status.
`default_nettype none
interface lfid_rsp_if;
    import lfid_pkg::*;

    logic    valid;
    logic    ready;
    t_id     granted_id;
    t_status status;

    modport source (output valid, output granted_id, output status, input ready);
    modport sink   (input valid, input granted_id, input status, output ready);
endinterface
`default_nettype wire

/* design/lfid_word_scan.sv */
// Word scanner: lowest free identifier inside one 32-bit word of the in-use map.
`default_nettype none
module lfid_word_scan (
    input  wire logic [lfid_pkg::WORD_BITS-1:0] i_word,
    input  wire lfid_pkg::t_limit               i_base,
    input  wire lfid_pkg::t_id                  i_first,
    input  wire lfid_pkg::t_limit               i_bound,
    output lfid_pkg::t_scan_res                 o_res
);
    import lfid_pkg::*;

    logic [WORD_BITS-1:0] w_cand;
    logic [WORD_BITS-1:0] w_lowest;
    logic [4:0]           w_off;
    t_limit               w_index;

    always_comb begin
        t_limit k;
        for (int b = 0; b < WORD_BITS; b++) begin
            k = i_base + t_limit'(b);
            w_cand[b] = !i_word[b] && (k >= {1'b0, i_first}) && (k < i_bound);
        end
    end

    // isolate the lowest candidate, then encode the one-hot position
    assign w_lowest = w_cand & (~w_cand + 32'd1);

    always_comb begin
        w_off = 5'd0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (w_lowest[b]) begin
                w_off = w_off | 5'(b);
            end
        end
    end

    assign w_index     = i_base + {4'd0, w_off};
    assign o_res.found = |w_cand;
    assign o_res.index = w_index[7:0];

endmodule
`default_nettype wire

/* design/lowest_free_id_allocator.sv */
// Top level: lowest-free identifier allocator with bitmap and word-serial scan.
//
// Keeps one in-use bit per identifier in flip-flops that reset clears at once,
// so the block is ready as soon as reset is released. One request is worked
// at a time; i_req.ready is high only while the sequencer is idle. Release,
// reserve and the unused kind are decided on acceptance and go straight to the
// hold state, which loads the result register. Allocate scans the map one 32-bit
// word per cycle through a single word scanner, starting at the word holding
// first_id and stopping at the first word with a free identifier or at the
// last word below the limit, so at most ceil(min(MAX_IDS,256)/32) words; it
// then goes to the hold state. An allocate with first_id at or above the limit
// skips the scan and answers full. A result that finds the result register
// still occupied waits for it in the hold state.
// The result register holds a response until it is taken, while the next
// request is already being worked.
`default_nettype none
module lowest_free_id_allocator #(
    parameter int MAX_IDS = 256
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire lfid_pkg::t_cfg_idx i_cfg_idx,
    input  wire lfid_pkg::t_limit  i_cfg_data,
    lfid_req_if.sink               i_req,
    lfid_rsp_if.source             o_rsp
);
    import lfid_pkg::*;

    localparam int MAP_DEPTH = (MAX_IDS < 256) ? MAX_IDS : 256;
    localparam int NWORDS    = (MAP_DEPTH + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int MAP_BITS  = NWORDS * WORD_BITS;
    localparam int MAP_IW    = $clog2(MAP_BITS);

    t_state              r_state, n_state;
    t_id                 r_first_id;
    t_limit              r_id_limit;
    logic [MAP_BITS-1:0] r_map, n_map;
    logic [WIDX-1:0]     r_word, n_word;
    t_id                 r_res_id, n_res_id;
    t_status             r_res_st, n_res_st;
    logic                r_out_valid, n_out_valid;
    t_id                 r_out_id, n_out_id;
    t_status             r_out_st, n_out_st;

    logic      w_accept;
    logic      w_out_free;
    t_limit    w_bound;
    t_limit    w_last;
    logic      w_last_word;
    logic      w_in_range;
    logic      w_map_bit;
    logic      w_start_full;
    t_limit    w_base;
    t_scan_res w_scan;

    assign w_bound      = (r_id_limit < t_limit'(MAP_DEPTH)) ? r_id_limit
                                                             : t_limit'(MAP_DEPTH);
    assign w_last       = w_bound - 9'd1;
    assign w_last_word  = (4'(r_word) == w_last[8:5]);
    assign w_start_full = ({1'b0, r_first_id} >= w_bound);
    assign w_in_range   = ({1'b0, i_req.id} < t_limit'(MAP_DEPTH));
    assign w_map_bit    = r_map[i_req.id[MAP_IW-1:0]];
    assign w_base       = t_limit'({r_word, 5'b00000});

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    lfid_word_scan u_scan (
        .i_word  (r_map[WORD_BITS*r_word +: WORD_BITS]),
        .i_base  (w_base),
        .i_first (r_first_id),
        .i_bound (w_bound),
        .o_res   (w_scan)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req.kind == KIND_ALLOC && !w_start_full) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_SCAN: begin
                if (w_scan.found || w_last_word) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_map       = r_map;
        n_word      = r_word;
        n_res_id    = r_res_id;
        n_res_st    = r_res_st;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_id    = r_out_id;
        n_out_st    = r_out_st;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res_id = 8'd0;
                    n_res_st = ST_OK;
                    n_word   = WIDX'(r_first_id[7:5]);
                    if (i_req.kind == KIND_ALLOC) begin
                        if (w_start_full) begin
                            n_res_st = ST_FULL;
                        end
                    end else if (i_req.kind == KIND_RELEASE) begin
                        if (w_in_range && w_map_bit) begin
                            n_map[i_req.id[MAP_IW-1:0]] = 1'b0;
                            n_res_id = i_req.id;
                        end else begin
                            n_res_st = ST_NOT_IN_USE;
                        end
                    end else if (i_req.kind == KIND_RESERVE) begin
                        if (!w_in_range) begin
                            n_res_st = ST_FULL;
                        end else if (w_map_bit) begin
                            n_res_st = ST_IN_USE;
                        end else begin
                            n_map[i_req.id[MAP_IW-1:0]] = 1'b1;
                            n_res_id = i_req.id;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (w_scan.found) begin
                    n_map[w_scan.index[MAP_IW-1:0]] = 1'b1;
                    n_res_id = w_scan.index;
                    n_res_st = ST_OK;
                end else if (w_last_word) begin
                    n_res_id = 8'd0;
                    n_res_st = ST_FULL;
                end else begin
                    n_word = r_word + 1'b1;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_id    = r_res_id;
                    n_out_st    = r_res_st;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first_id  <= FIRST_ID_RESET;
            r_id_limit  <= ID_LIMIT_RESET;
            r_map       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_map       <= n_map;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FIRST_ID: r_first_id <= i_cfg_data[7:0];
                    CFG_ID_LIMIT: r_id_limit <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word   <= n_word;
        r_res_id <= n_res_id;
        r_res_st <= n_res_st;
        r_out_id <= n_out_id;
        r_out_st <= n_out_st;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.granted_id = r_out_id;
    assign o_rsp.status     = r_out_st;

    a_err_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |-> (o_rsp.granted_id == 8'd0))
        else $error("failed response carries a nonzero id");

    a_grant_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && w_scan.found) |->
        ({1'b0, w_scan.index} >= {1'b0, r_first_id} && {1'b0, w_scan.index} < w_bound))
        else $error("allocated id outside first_id..limit window");

    a_grant_marks_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && w_scan.found) |=>
        r_map[$past(w_scan.index[MAP_IW-1:0])])
        else $error("allocated id not marked in use");

    a_hold_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD && w_out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("pending result not moved to output register");

endmodule
`default_nettype wire

/* dv/lowest_free_id_allocator_test.sv */
// Testbench for the lowest-free identifier allocator: directed and random requests, scoreboard check.
`timescale 1ns / 100ps
module lowest_free_id_allocator_test;
    import lfid_pkg::*;

    // unused kind code: no operation, always answered ok with id 0
    localparam t_kind KIND_NOP       = 2'd3;
    localparam int    MAX_WAIT       = 12;
    localparam int    WATCHDOG_LIMIT = 1000;
    localparam int    RANDOM_ITEMS   = 1830;

    typedef struct packed {
        t_id     granted_id;
        t_status status;
    } t_grant;

    class lfid_grant_checker;
        bit [255:0] in_use;
        t_id        first_id;
        t_limit     id_limit;
        t_grant     pending_grants[$];
        int         errors;
        int         checked;
        int         status_seen[4];

        function new();
            in_use   = '0;
            first_id = FIRST_ID_RESET;
            id_limit = ID_LIMIT_RESET;
        endfunction

        function void set_config(t_cfg_idx idx, t_limit data);
            if (idx == CFG_FIRST_ID) begin
                first_id = data[7:0];
            end else begin
                id_limit = data;
            end
        endfunction

        // work out the reply for one accepted request and update the in-use map
        function void log_request(t_kind kind, t_id id);
            t_grant g;
            int     bound;
            g.granted_id = '0;
            g.status     = ST_OK;
            case (kind)
                KIND_ALLOC: begin
                    // search window clamps at 256 so every grant fits in 8 bits
                    bound    = (id_limit > 256) ? 256 : int'(id_limit);
                    g.status = ST_FULL;
                    for (int k = first_id; k < bound; k++) begin
                        if (!in_use[k]) begin
                            in_use[k]    = 1'b1;
                            g.granted_id = t_id'(k);
                            g.status     = ST_OK;
                            break;
                        end
                    end
                end
                KIND_RELEASE: begin
                    if (in_use[id]) begin
                        in_use[id]   = 1'b0;
                        g.granted_id = id;
                    end else begin
                        g.status = ST_NOT_IN_USE;
                    end
                end
                KIND_RESERVE: begin
                    // reserve ignores first_id and id_limit
                    if (in_use[id]) begin
                        g.status = ST_IN_USE;
                    end else begin
                        in_use[id]   = 1'b1;
                        g.granted_id = id;
                    end
                end
                default: ;
            endcase
            pending_grants.push_back(g);
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_grant(t_id granted_id, t_status status);
            t_grant want;
            if (pending_grants.size() == 0) begin
                report($sformatf("response with nothing outstanding: id %0d status %0d",
                                 granted_id, status));
                return;
            end
            want = pending_grants.pop_front();
            checked++;
            status_seen[status]++;
            if (granted_id !== want.granted_id) begin
                report($sformatf("granted_id %0d, want %0d (status %0d)",
                                 granted_id, want.granted_id, want.status));
            end
            if (status !== want.status) begin
                report($sformatf("status %0d, want %0d (id %0d)", status, want.status,
                                 want.granted_id));
            end
        endtask

        // random identifier currently held, or any identifier when the map is empty
        function t_id any_in_use();
            int n;
            int pick;
            n = $countones(in_use);
            if (n == 0) begin
                return t_id'($urandom_range(0, 255));
            end
            pick = $urandom_range(0, n - 1);
            for (int k = 0; k < 256; k++) begin
                if (in_use[k]) begin
                    if (pick == 0) begin
                        return t_id'(k);
                    end
                    pick--;
                end
            end
            return '0;
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     i_cfg_we;
    t_cfg_idx i_cfg_idx;
    t_limit   i_cfg_data;

    lfid_req_if req_ch();
    lfid_rsp_if rsp_ch();

    lowest_free_id_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    lfid_grant_checker grants = new();

    int requests_sent;
    int settings_used;
    int idle_cycles;
    bit sender_eager;
    int sender_left;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // no transaction on either side for too long means the block hung
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (req_ch.valid && req_ch.ready) ||
            (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", idle_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // response side: random stalls, with stretches of always-ready
    initial begin
        int stall;
        bit eager;
        int left;
        left          = 0;
        eager         = 1'b0;
        rsp_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (left == 0) begin
                eager = ($urandom_range(0, 3) == 0);
                left  = $urandom_range(5, 40);
            end
            left--;
            stall = eager ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            grants.check_grant(rsp_ch.granted_id, rsp_ch.status);
        end
    end

    // leaves valid high on return so a back-to-back request keeps it up
    task send_request(t_kind kind, t_id id);
        int gap;
        if (sender_left == 0) begin
            sender_eager = ($urandom_range(0, 3) == 0);
            sender_left  = $urandom_range(5, 40);
        end
        sender_left--;
        gap = sender_eager ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind  <= kind;
        req_ch.id    <= id;
        do @(posedge i_clk); while (!req_ch.ready);
        grants.log_request(kind, id);
        requests_sent++;
    endtask

    task drain_requests();
        req_ch.valid <= 1'b0;
        while (grants.pending_grants.size() > 0) @(posedge i_clk);
    endtask

    // only called with the block idle
    task program_ids(t_limit first_val, t_limit limit_val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FIRST_ID;
        i_cfg_data <= first_val;
        @(posedge i_clk);
        grants.set_config(CFG_FIRST_ID, first_val);
        i_cfg_idx  <= CFG_ID_LIMIT;
        i_cfg_data <= limit_val;
        @(posedge i_clk);
        grants.set_config(CFG_ID_LIMIT, limit_val);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // mix 0 fills the map, 1 frees it, 2 is balanced
    task random_request(int mix);
        int r;
        int w_alloc;
        int w_release;
        r = $urandom_range(0, 99);
        case (mix)
            0:       begin w_alloc = 60; w_release = 15; end
            1:       begin w_alloc = 25; w_release = 55; end
            default: begin w_alloc = 40; w_release = 30; end
        endcase
        if (r < w_alloc) begin
            send_request(KIND_ALLOC, t_id'($urandom_range(0, 255)));
        end else if (r < w_alloc + w_release) begin
            send_request(KIND_RELEASE, ($urandom_range(0, 4) != 0) ? grants.any_in_use() :
                                       t_id'($urandom_range(0, 255)));
        end else if (r < 95) begin
            // half near the allocate window so reserve and allocate collide
            send_request(KIND_RESERVE, $urandom_range(0, 1) ?
                         t_id'(grants.first_id + $urandom_range(0, 15)) :
                         t_id'($urandom_range(0, 255)));
        end else begin
            send_request(KIND_NOP, t_id'($urandom_range(0, 255)));
        end
    endtask

    task pick_random_setting();
        t_limit first_val;
        first_val = t_limit'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            0: program_ids(9'd0, 9'd256);
            1: program_ids(first_val, first_val + t_limit'($urandom_range(1, 24)));
            2: program_ids(first_val, t_limit'($urandom_range(0, 511)));
            3: begin
                if ($urandom_range(0, 1)) begin
                    program_ids(9'd255, 9'd256);
                end else begin
                    program_ids(9'd0, 9'd1);
                end
            end
            // upper data bit is dropped for first_id
            4: program_ids(t_limit'($urandom_range(0, 511)), $urandom_range(0, 1) ? 9'd0 : 9'd511);
            default: begin
                first_val = t_limit'($urandom_range(0, 63));
                program_ids(first_val, first_val + t_limit'($urandom_range(1, 64)));
            end
        endcase
    endtask

    initial begin
        int mix;
        int n;
        requests_sent = 0;
        settings_used = 0;
        idle_cycles   = 0;
        sender_left   = 0;
        sender_eager  = 1'b0;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_FIRST_ID;
        i_cfg_data   <= '0;
        req_ch.valid <= 1'b0;
        req_ch.kind  <= KIND_ALLOC;
        req_ch.id    <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset window: first_id 0, limit 256
        send_request(KIND_ALLOC, 8'd0);
        send_request(KIND_ALLOC, 8'd255);
        send_request(KIND_ALLOC, 8'd0);
        send_request(KIND_RELEASE, 8'd1);
        send_request(KIND_RELEASE, 8'd1);
        send_request(KIND_ALLOC, 8'd0);
        send_request(KIND_RESERVE, 8'd255);
        send_request(KIND_RESERVE, 8'd255);
        send_request(KIND_RELEASE, 8'd0);
        send_request(KIND_RESERVE, 8'd0);
        send_request(KIND_NOP, 8'd255);
        send_request(KIND_RELEASE, 8'd200);
        send_request(KIND_ALLOC, 8'd0);
        // top identifier only: full while held, granted once freed
        drain_requests();
        program_ids(9'd255, 9'd256);
        send_request(KIND_ALLOC, 8'd0);
        send_request(KIND_RELEASE, 8'd255);
        send_request(KIND_ALLOC, 8'd0);
        // zero limit
        drain_requests();
        program_ids(9'd0, 9'd0);
        send_request(KIND_ALLOC, 8'd0);
        // first id above limit; reserve still works
        drain_requests();
        program_ids(9'h105, 9'd1);
        send_request(KIND_ALLOC, 8'd0);
        send_request(KIND_RESERVE, 8'd128);
        // limit past the map size
        drain_requests();
        program_ids(9'd0, 9'd511);
        send_request(KIND_ALLOC, 8'd0);
        send_request(KIND_RELEASE, 8'd128);

        while (requests_sent < RANDOM_ITEMS + 21) begin
            drain_requests();
            pick_random_setting();
            mix = $urandom_range(0, 2);
            n   = $urandom_range(40, 160);
            repeat (n) random_request(mix);
        end

        drain_requests();
        repeat (20) @(posedge i_clk);
        $display("Ran %0d requests over %0d id window settings; replies checked %0d",
                 requests_sent, settings_used, grants.checked);
        $display("Replies by status: ok %0d, full %0d, not in use %0d, already in use %0d",
                 grants.status_seen[ST_OK], grants.status_seen[ST_FULL],
                 grants.status_seen[ST_NOT_IN_USE], grants.status_seen[ST_IN_USE]);
        if (grants.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
